@@ sv/wfvs_pkg.sv @@
`default_nettype none
package wfvs_pkg;
  localparam int MAX_WAYPOINTS = 256;
  localparam int JOINTS = 6;
  localparam int IDX_W = $clog2(MAX_WAYPOINTS + 1);
  localparam int ADDR_W = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int JW = 3;

  typedef enum logic [1:0] {
    ST_CMD  = 2'd0,
    ST_DONE = 2'd1,
    ST_IDLE = 2'd2
  } status_t;

  localparam logic [1:0] REG_GOAL_START = 2'd0;
  localparam logic [1:0] REG_MAX_VEL = 2'd1;
  localparam logic [1:0] REG_TOL = 2'd2;
  localparam logic [1:0] REG_DEF_VEL = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_READ1, S_CHECK, S_READ2, S_DIFF, S_DIV, S_EMIT
  } state_t;
endpackage
`default_nettype wire

@@ sv/wfvs_lane.sv @@
`default_nettype none
// One joint lane: holds a column of the waypoint table, finds the distance to
// the measured position, and divides |diff|*max_velocity by the largest
// distance one quotient bit per cycle.
module wfvs_lane (
  input  wire logic clk,
  input  wire logic wr_en,
  input  wire logic [wfvs_pkg::ADDR_W-1:0] addr,
  input  wire logic signed [15:0] wr_data,
  input  wire logic signed [15:0] meas,
  input  wire logic [15:0] tol,
  input  wire logic [15:0] max_vel,
  input  wire logic div_start,
  input  wire logic div_run,
  input  wire logic [16:0] divisor,
  output logic signed [15:0] tgt,
  output logic [16:0] diff,
  output logic near,
  output logic [15:0] quot
);
  import wfvs_pkg::*;

  logic signed [15:0] mem [MAX_WAYPOINTS];
  logic [32:0] dividend;
  logic [33:0] rem;
  logic [32:0] q;
  logic [33:0] rem_shift;
  logic signed [16:0] d;

  // Column memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    tgt <= mem[addr];
  end

  // Absolute difference and arrival check.
  always_comb begin
    d = 17'(tgt) - 17'(meas);
    diff = d[16] ? 17'(-d) : 17'(d);
    near = (diff <= {1'b0, tol});
  end

  assign rem_shift = {rem[32:0], dividend[32]};

  // Restoring division: 33 quotient bits, one per cycle. The quotient holds
  // once the steps are done so the words can read it.
  always_ff @(posedge clk) begin
    if (div_start) begin
      dividend <= 33'(diff) * 33'(max_vel);
      rem <= '0;
      q <= '0;
    end else if (div_run) begin
      dividend <= {dividend[31:0], 1'b0};
      if (rem_shift >= {17'd0, divisor}) begin
        rem <= rem_shift - {17'd0, divisor};
        q <= {q[31:0], 1'b1};
      end else begin
        rem <= rem_shift;
        q <= {q[31:0], 1'b0};
      end
    end
  end

  assign quot = q[15:0];
endmodule
`default_nettype wire

@@ sv/wfvs_merge.sv @@
`default_nettype none
// Merging stage: all-arrived flag and the largest distance over the lanes.
module wfvs_merge (
  input  wire logic [wfvs_pkg::JOINTS-1:0] near,
  input  wire logic [wfvs_pkg::JOINTS-1:0][16:0] diff,
  output logic all_near,
  output logic [16:0] dmax
);
  import wfvs_pkg::*;

  always_comb begin
    all_near = &near;
    dmax = '0;
    for (int j = 0; j < JOINTS; j++) begin
      if (diff[j] > dmax) begin
        dmax = diff[j];
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/waypoint_follower_velocity_sync_unit.sv @@
`default_nettype none
// Waypoint words give no result. A tick that gives commands holds busy through
// two table reads with the arrival check, a 33-step divider in each joint lane,
// then six words on consecutive cycles; the last one appears when the next word
// can be taken. Idle and finished ticks give a single status word. The receiver
// cannot stall. rst synchronously resets control state and configuration to
// their defaults, not the table.
module waypoint_follower_velocity_sync_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic kind,
  input  wire logic first,
  input  wire logic last,
  input  wire logic signed [15:0] value_0,
  input  wire logic signed [15:0] value_1,
  input  wire logic signed [15:0] value_2,
  input  wire logic signed [15:0] value_3,
  input  wire logic signed [15:0] value_4,
  input  wire logic signed [15:0] value_5,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic strobe,
  output logic [1:0] status,
  output logic [2:0] joint,
  output logic signed [15:0] target,
  output logic [15:0] speed,
  output logic final_res
);
  import wfvs_pkg::*;

  logic goal_start;
  logic [15:0] max_velocity, arrive_tolerance, default_velocity;
  logic [IDX_W-1:0] wp_count, cur_idx;
  logic running;
  state_t state, state_next;
  logic [5:0] cnt;
  logic signed [15:0] meas [JOINTS];
  logic signed [15:0] vin [6];
  logic [ADDR_W-1:0] addr;
  logic wr_en;
  logic [JOINTS-1:0] near;
  logic [JOINTS-1:0][16:0] diff;
  logic signed [15:0] tgt [JOINTS];
  logic [15:0] quot [JOINTS];
  logic all_near;
  logic [16:0] dmax, dmax_r;
  logic [JW-1:0] ej;
  logic accept;
  logic [IDX_W-1:0] cnt_after;

  assign vin[0] = value_0;
  assign vin[1] = value_1;
  assign vin[2] = value_2;
  assign vin[3] = value_3;
  assign vin[4] = value_4;
  assign vin[5] = value_5;
  assign accept = start && !busy;
  assign busy = (state != S_IDLE);
  assign cnt_after = first ? IDX_W'(0) : wp_count;
  assign wr_en = accept && !kind && (cnt_after < IDX_W'(MAX_WAYPOINTS));
  assign addr = wr_en ? cnt_after[ADDR_W-1:0] : cur_idx[ADDR_W-1:0];

  // Lanes.
  for (genvar g = 0; g < JOINTS; g++) begin : g_lane
    wfvs_lane u_lane (
      .clk(clk), .wr_en(wr_en), .addr(addr), .wr_data(vin[g]), .meas(meas[g]),
      .tol(arrive_tolerance), .max_vel(max_velocity),
      .div_start(state == S_DIFF), .div_run(state == S_DIV), .divisor(dmax_r),
      .tgt(tgt[g]), .diff(diff[g]), .near(near[g]), .quot(quot[g])
    );
  end

  wfvs_merge u_merge (.near(near), .diff(diff), .all_near(all_near), .dmax(dmax));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_start <= 1'b1;
      max_velocity <= 16'd8000;
      arrive_tolerance <= 16'd100;
      default_velocity <= 16'd2000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GOAL_START: goal_start <= cfg_data[0];
        REG_MAX_VEL: max_velocity <= cfg_data;
        REG_TOL: arrive_tolerance <= cfg_data;
        REG_DEF_VEL: default_velocity <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept && kind) state_next = running ? S_READ1 : S_EMIT;
      S_READ1: state_next = (cur_idx < wp_count) ? S_CHECK : S_EMIT;
      S_CHECK: state_next = S_READ2;
      S_READ2: state_next = (cur_idx < wp_count) ? S_DIFF : S_EMIT;
      S_DIFF: state_next = S_DIV;
      S_DIV: if (cnt == 6'd32) state_next = S_EMIT;
      S_EMIT: if (!running || (cur_idx >= wp_count) || ej == JW'(JOINTS - 1))
                state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control and path state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wp_count <= '0;
      cur_idx <= '0;
      running <= 1'b0;
      cnt <= '0;
      ej <= '0;
      strobe <= 1'b0;
    end else begin
      state <= state_next;
      strobe <= (state == S_EMIT);
      if (accept) begin
        for (int j = 0; j < JOINTS; j++) meas[j] <= vin[j];
        if (!kind) begin
          running <= last;
          wp_count <= wr_en ? cnt_after + IDX_W'(1) : cnt_after;
          if (last) begin
            cur_idx <= (goal_start && (wr_en || cnt_after != '0)) ?
                       (wr_en ? cnt_after : cnt_after - IDX_W'(1)) : IDX_W'(0);
          end
        end
      end
      if (state == S_CHECK && all_near) cur_idx <= cur_idx + IDX_W'(1);
      if (state == S_DIFF) begin
        dmax_r <= dmax;
        cnt <= '0;
      end
      if (state == S_DIV) cnt <= cnt + 6'd1;
      if (state == S_EMIT) begin
        if (!running) begin
          status <= ST_IDLE;
          joint <= '0; target <= '0; speed <= '0; final_res <= 1'b1;
        end else if (cur_idx >= wp_count) begin
          status <= ST_DONE;
          joint <= '0; target <= '0; speed <= '0; final_res <= 1'b1;
          running <= 1'b0;
        end else begin
          status <= ST_CMD;
          joint <= ej;
          target <= tgt[ej];
          speed <= (dmax_r == '0) ? default_velocity : quot[ej];
          final_res <= (ej == JW'(JOINTS - 1));
          ej <= (ej == JW'(JOINTS - 1)) ? '0 : ej + JW'(1);
        end
      end
    end
  end

  // A word only leaves while a tick is in progress.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy)) else $error("word without tick");
  // The index never passes the path length while a path is followed.
  a_idx: assert property (@(posedge clk) disable iff (rst)
    cur_idx <= wp_count || !running) else $error("index past path");
  // Nothing is accepted while busy.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (start && busy) |=> !(strobe && $past(state) == S_IDLE))
    else $error("accept while busy");
endmodule
`default_nettype wire

@@ dv/waypoint_follower_velocity_sync_unit_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module waypoint_follower_velocity_sync_unit_tb;
  import wfvs_pkg::*;

  // Result word as seen on the output ports.
  typedef struct packed {
    logic [1:0] status;
    logic [2:0] joint;
    logic [15:0] target;
    logic [15:0] speed;
    logic final_res;
  } cmd_word_t;

  // One stimulus row; has_exp marks rows with a typed-in result.
  typedef struct {
    logic kind;
    logic first;
    logic last;
    logic [15:0] v [6];
    bit has_exp;
    cmd_word_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic kind = 1'b0, first = 1'b0, last = 1'b0;
  logic signed [15:0] value_0 = '0, value_1 = '0, value_2 = '0;
  logic signed [15:0] value_3 = '0, value_4 = '0, value_5 = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic strobe;
  logic [1:0] status;
  logic [2:0] joint;
  logic signed [15:0] target;
  logic [15:0] speed;
  logic final_res;

  waypoint_follower_velocity_sync_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .first(first),
    .last(last), .value_0(value_0), .value_1(value_1), .value_2(value_2),
    .value_3(value_3), .value_4(value_4), .value_5(value_5), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .strobe(strobe), .status(status),
    .joint(joint), .target(target), .speed(speed), .final_res(final_res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state and configuration.
  logic signed [15:0] path_tbl [MAX_WAYPOINTS][JOINTS];
  int unsigned path_len, path_pos;
  bit following;
  bit goal_only;
  logic [15:0] vel_max, tol, vel_default;

  cmd_word_t cmd_q[$];
  int errors, mismatches, idle_cycles;
  bit quiet;

  function automatic logic [16:0] abs_gap(logic signed [15:0] a, logic signed [15:0] b);
    logic signed [16:0] d;
    d = 17'(a) - 17'(b);
    return d < 0 ? 17'(-d) : 17'(d);
  endfunction

  // Applies one accepted word to the predictor and queues its results.
  task automatic follow_word(input row_t r);
    logic [16:0] d [JOINTS];
    logic [16:0] dmax;
    bit arrived;
    cmd_word_t w;
    if (!r.kind) begin
      following = 0;
      if (r.first) path_len = 0;
      if (path_len < MAX_WAYPOINTS) begin
        for (int j = 0; j < JOINTS; j++) path_tbl[path_len][j] = r.v[j];
        path_len++;
      end
      if (r.last) begin
        following = 1;
        path_pos = (goal_only && path_len > 0) ? path_len - 1 : 0;
      end
      return;
    end
    w = '0;
    w.final_res = 1'b1;
    if (!following) begin
      w.status = ST_IDLE;
      cmd_q = {cmd_q, w};
      return;
    end
    if (path_pos < path_len) begin
      arrived = 1;
      for (int j = 0; j < JOINTS; j++)
        if (abs_gap(path_tbl[path_pos][j], r.v[j]) > 17'(tol)) arrived = 0;
      if (arrived) path_pos++;
    end
    if (path_pos >= path_len) begin
      following = 0;
      w.status = ST_DONE;
      cmd_q = {cmd_q, w};
      return;
    end
    dmax = '0;
    for (int j = 0; j < JOINTS; j++) begin
      d[j] = abs_gap(path_tbl[path_pos][j], r.v[j]);
      if (d[j] > dmax) dmax = d[j];
    end
    for (int j = 0; j < JOINTS; j++) begin
      w.status = ST_CMD;
      w.joint = 3'(j);
      w.target = path_tbl[path_pos][j];
      w.speed = dmax > 0 ? 16'((64'(d[j]) * 64'(vel_max)) / 64'(dmax)) : vel_default;
      w.final_res = (j == JOINTS - 1);
      cmd_q = {cmd_q, w};
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      cmd_word_t got, want;
      got = '{status, joint, target, speed, final_res};
      if (cmd_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected word %h", got);
      end else begin
        want = cmd_q.pop_front();
        if (got !== want) begin
          errors++;
          if (mismatches++ < 10)
            $display("word mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  // Watchdog on cycles with no acceptance on either side.
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("waypoint_follower_velocity_sync_unit test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    start <= 1'b0;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GOAL_START: goal_only = val[0];
      REG_MAX_VEL: vel_max = val;
      REG_TOL: tol = val;
      default: vel_default = val;
    endcase
  endtask

  task automatic drain();
    start <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Presents one word and holds it until accepted.
  task automatic send_word(input row_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    start <= 1'b1;
    kind <= r.kind;
    first <= r.first;
    last <= r.last;
    value_0 <= r.v[0]; value_1 <= r.v[1]; value_2 <= r.v[2];
    value_3 <= r.v[3]; value_4 <= r.v[4]; value_5 <= r.v[5];
    @(posedge clk);
    while (busy) @(posedge clk);
    if (r.has_exp) begin
      follow_word(r);
      if (cmd_q.size() == 0 || cmd_q[$] !== r.exp) begin
        errors++;
        $display("directed row predictor disagrees with typed result");
      end
    end else follow_word(r);
  endtask

  function automatic row_t mk(int k, int f, int l, int a, int spread);
    row_t r;
    r.kind = 1'(k); r.first = 1'(f); r.last = 1'(l); r.has_exp = 0; r.exp = '0;
    for (int j = 0; j < 6; j++)
      r.v[j] = 16'(a + (spread ? $signed($urandom_range(0, 2 * spread)) - spread : 0));
    return r;
  endfunction

  function automatic row_t mk_exp(int k, int f, int l, int a, logic [1:0] st);
    row_t r;
    r = mk(k, f, l, a, 0);
    r.has_exp = 1;
    r.exp = '0;
    r.exp.status = st;
    r.exp.final_res = 1'b1;
    return r;
  endfunction

  row_t dir_tbl[$];
  row_t r;

  initial begin
    errors = 0; mismatches = 0; idle_cycles = 0; quiet = 0;
    path_len = 0; path_pos = 0; following = 0;
    goal_only = 1; vel_max = 8000; tol = 100; vel_default = 2000;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: idle after reset, extremes and goal-only walks.
    dir_tbl = {dir_tbl, mk_exp(1, 0, 0, 0, ST_IDLE)};
    dir_tbl = {dir_tbl, mk(0, 1, 0, 32767, 0)};
    dir_tbl = {dir_tbl, mk(0, 0, 1, -32768, 0)};
    dir_tbl = {dir_tbl, mk(1, 0, 0, 32767, 0)};
    dir_tbl = {dir_tbl, mk(1, 0, 0, -32768, 0)};
    dir_tbl = {dir_tbl, mk(1, 0, 0, -32700, 50)};
    dir_tbl = {dir_tbl, mk_exp(1, 0, 0, 0, ST_IDLE)};
    dir_tbl = {dir_tbl, mk(0, 1, 1, 0, 0)};
    dir_tbl = {dir_tbl, mk(1, 0, 0, 1000, 900)};
    dir_tbl = {dir_tbl, mk_exp(1, 0, 0, 0, ST_DONE)};
    foreach (dir_tbl[i]) send_word(dir_tbl[i]);
    drain();

    // Walk every waypoint with zero tolerance; exact hits advance along the path.
    write_reg(REG_GOAL_START, 16'd0);
    write_reg(REG_TOL, 16'd0);
    write_reg(REG_DEF_VEL, 16'hFFFF);
    write_reg(REG_MAX_VEL, 16'hFFFF);
    send_word(mk(0, 1, 0, 5, 0));
    send_word(mk(0, 0, 1, 7, 0));
    send_word(mk(1, 0, 0, 6, 0));
    send_word(mk(1, 0, 0, 5, 0));
    send_word(mk(1, 0, 0, 7, 0));
    send_word(mk(1, 0, 0, 0, 0));
    drain();

    // Table overflow: fill past capacity with random positions.
    for (int i = 0; i < MAX_WAYPOINTS + 3; i++) begin
      quiet = 1;
      send_word(mk(0, int'(i == 0), int'(i == MAX_WAYPOINTS + 2),
                   $signed($urandom()) % 32768, 0));
    end
    quiet = 0;
    write_reg(REG_GOAL_START, 16'd1);
    send_word(mk(0, 0, 1, 100, 0));
    send_word(mk(1, 0, 0, 100, 0));
    drain();

    // Random phases with varied settings.
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_GOAL_START, 16'($urandom_range(0, 1)));
      write_reg(REG_MAX_VEL, ph == 0 ? 16'd0 : 16'($urandom()));
      write_reg(REG_TOL, ph == 1 ? 16'hFFFF : 16'($urandom_range(0, 3000)));
      write_reg(REG_DEF_VEL, 16'($urandom()));
      quiet = (ph == 4);
      for (int k = 0; k < 30; ) begin
        int n, base;
        n = $urandom_range(0, 4);
        base = $signed($urandom()) % 30000;
        if ($urandom_range(0, 5) == 0) begin
          r = mk($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                 $signed($urandom()) % 32768, $urandom_range(0, 32767));
          for (int j = 0; j < 6; j++) r.v[j] = 16'($urandom());
          send_word(r); k++;
        end else begin
          for (int i = 0; i < n; i++) begin
            send_word(mk(0, int'(i == 0), int'(i == n - 1), base + 500 * i, 2000)); k++;
          end
          if (n == 0) begin
            send_word(mk(0, 1, 1, base, 2000)); k++;
          end
          for (int t = 0; t < 2 * n + 3; t++) begin
            int a;
            a = following && path_pos < path_len ? path_tbl[path_pos][0] : base;
            send_word(mk(1, 0, 0, a, $urandom_range(0, 1) ? 60 : 4000)); k++;
          end
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("waypoint_follower_velocity_sync_unit test passed");
    end else begin
      $display("waypoint_follower_velocity_sync_unit test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
